// ===== rtl/trilin_pkg.sv =====
// ----------------------------------------------------------------------------
// trilin_pkg
// shared types, constants and the divider step of the trilinear interpolator
// ----------------------------------------------------------------------------
package trilin_pkg;

    localparam int DEF_COORD_WIDTH = 32;
    localparam int DEF_VALUE_WIDTH = 16;
    localparam int CELL_WIDTH      = 32;
    localparam int FRAC_WIDTH      = 17;
    localparam int DIV_STEPS       = 16;
    localparam int CFG_IDX_WIDTH   = 2;

    localparam logic [CELL_WIDTH-1:0] CELL_RESET = 32'h0001_0000;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_CELL_X = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_CELL_Y = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_CELL_Z = 2'd2;

    typedef struct packed {
        logic                  fixed;
        logic                  flag;
        logic [FRAC_WIDTH-1:0] quo;
        logic [CELL_WIDTH-1:0] rem;
    } axis_t;

    typedef logic [2:0][CELL_WIDTH-1:0] cell_set_t;

    function automatic axis_t div_step(input axis_t a, input logic [CELL_WIDTH-1:0] cell_size);
        axis_t             res;
        logic [CELL_WIDTH:0] r2;
        logic [CELL_WIDTH:0] diff;
        logic              qbit;
        res  = a;
        r2   = {a.rem, 1'b0};
        diff = r2 - {1'b0, cell_size};
        qbit = 1'b0;
        if (!a.fixed)
        begin
            if (r2 >= {1'b0, cell_size})
            begin
                qbit    = 1'b1;
                res.rem = diff[CELL_WIDTH-1:0];
            end
            else
            begin
                res.rem = r2[CELL_WIDTH-1:0];
            end
        end
        res.quo = {a.quo[FRAC_WIDTH-2:0], qbit};
        return res;
    endfunction

endpackage

// ===== rtl/trilinear_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// trilinear_interpolator_core
// throughput: one request per cycle while out_stall does not hold the result, through the 16-stage fraction divider
// a two-entry queue decouples the classifier from the divider and lerp pipe
// reset: all valids cleared, cell sizes set to 1.0
// ----------------------------------------------------------------------------
module trilinear_interpolator_core
    import trilin_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]      cfg_index,
    input  logic [CELL_WIDTH-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic [2*VALUE_WIDTH-1:0]      corners_y0z0,
    input  logic [2*VALUE_WIDTH-1:0]      corners_y1z0,
    input  logic [2*VALUE_WIDTH-1:0]      corners_y0z1,
    input  logic [2*VALUE_WIDTH-1:0]      corners_y1z1,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] interpolated,
    output logic [2:0]                    out_of_cell
);

    localparam int QW = 3 * $bits(axis_t) + 8 * VALUE_WIDTH;

    cell_set_t                  cell_reg;
    logic                       push;
    logic                       q_full;
    logic                       q_not_empty;
    logic                       pop;
    axis_t [2:0]                f_axes;
    logic [8*VALUE_WIDTH-1:0]   f_corners;
    axis_t [2:0]                b_axes;
    logic [8*VALUE_WIDTH-1:0]   b_corners;
    logic [QW-1:0]              q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= {CELL_RESET, CELL_RESET, CELL_RESET};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CELL_X: cell_reg[0] <= cfg_data;
                CFG_CELL_Y: cell_reg[1] <= cfg_data;
                CFG_CELL_Z: cell_reg[2] <= cfg_data;
                default:    ;
            endcase
        end
    end

    trilin_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .point     ({point_z, point_y, point_x}),
        .origin    ({origin_z, origin_y, origin_x}),
        .corners   ({corners_y1z1, corners_y0z1, corners_y1z0, corners_y0z0}),
        .cell_size (cell_reg),
        .push      (push),
        .q_full    (q_full),
        .axes      (f_axes),
        .corners_q (f_corners)
    );

    trilin_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     ({f_axes, f_corners}),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    assign {b_axes, b_corners} = q_rdata;

    trilin_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .pop          (pop),
        .axes_in      (b_axes),
        .corners_in   (b_corners),
        .cell_size    (cell_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .interpolated (interpolated),
        .out_of_cell  (out_of_cell)
    );

endmodule

// ===== rtl/trilin_front.sv =====
// ----------------------------------------------------------------------------
// trilin_front
// accepts requests, forms per-axis offsets and classifies them for the divider
// ----------------------------------------------------------------------------
module trilin_front
    import trilin_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0][COORD_WIDTH-1:0]   point,
    input  logic [2:0][COORD_WIDTH-1:0]   origin,
    input  logic [8*VALUE_WIDTH-1:0]      corners,
    input  cell_set_t                     cell_size,
    output logic                          push,
    input  logic                          q_full,
    output axis_t [2:0]                   axes,
    output logic [8*VALUE_WIDTH-1:0]      corners_q
);

    localparam int CMPW = (COORD_WIDTH > CELL_WIDTH) ? COORD_WIDTH : CELL_WIDTH;

    logic        valid_reg;
    axis_t [2:0] axes_reg;
    axis_t [2:0] axes_next;
    logic [8*VALUE_WIDTH-1:0] corners_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [COORD_WIDTH:0] diff;
            logic [CMPW-1:0]      d_ext;
            logic [CMPW-1:0]      c_ext;
            diff  = {point[i][COORD_WIDTH-1], point[i]}
                  - {origin[i][COORD_WIDTH-1], origin[i]};
            d_ext = CMPW'(diff[COORD_WIDTH-1:0]);
            c_ext = CMPW'(cell_size[i]);
            axes_next[i].fixed = 1'b1;
            axes_next[i].flag  = 1'b0;
            axes_next[i].quo   = '0;
            axes_next[i].rem   = '0;
            if (diff[COORD_WIDTH])
            begin
                axes_next[i].flag = 1'b1;
            end
            else if (d_ext > c_ext)
            begin
                axes_next[i].flag = 1'b1;
                axes_next[i].quo  = FRAC_WIDTH'(1);
            end
            else if (d_ext == '0)
            begin
                axes_next[i].quo = '0;
            end
            else if (d_ext == c_ext)
            begin
                axes_next[i].quo = FRAC_WIDTH'(1);
            end
            else
            begin
                axes_next[i].fixed = 1'b0;
                axes_next[i].rem   = d_ext[CELL_WIDTH-1:0];
            end
        end
    end

    assign in_stall  = valid_reg && q_full;
    assign push      = valid_reg && !q_full;
    assign axes      = axes_reg;
    assign corners_q = corners_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            axes_reg    <= axes_next;
            corners_reg <= corners;
        end
    end

endmodule

// ===== rtl/trilin_queue.sv =====
// ----------------------------------------------------------------------------
// trilin_queue
// two-entry queue between the classifier and the interpolation pipeline
// ----------------------------------------------------------------------------
module trilin_queue
    import trilin_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rdata     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("pop from empty queue");

endmodule

// ===== rtl/trilin_back.sv =====
// ----------------------------------------------------------------------------
// trilin_back
// pipelined fraction divider followed by x, y and z lerp stages
// ----------------------------------------------------------------------------
module trilin_back
    import trilin_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_not_empty,
    output logic                          pop,
    input  axis_t [2:0]                   axes_in,
    input  logic [8*VALUE_WIDTH-1:0]      corners_in,
    input  cell_set_t                     cell_size,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] interpolated,
    output logic [2:0]                    out_of_cell
);

    localparam int VW = VALUE_WIDTH;
    localparam int AW = VW + 19;

    function automatic logic signed [VW-1:0] lerp(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b,
                                                  input logic [FRAC_WIDTH-1:0] t);
        logic signed [FRAC_WIDTH:0] ts;
        logic signed [FRAC_WIDTH:0] tc;
        logic signed [AW-1:0]       acc;
        ts  = $signed({1'b0, t});
        tc  = $signed({2'b01, {(FRAC_WIDTH-1){1'b0}}}) - ts;
        acc = a * tc + b * ts;
        return acc[VW+15:16];
    endfunction

    logic                      en;
    logic                      dv_valid_reg [DIV_STEPS];
    axis_t [2:0]               dv_axes_reg  [DIV_STEPS];
    logic [8*VW-1:0]           dv_corn_reg  [DIV_STEPS];

    logic                      x_valid_reg;
    logic signed [VW-1:0]      x_val_reg [4];
    logic [FRAC_WIDTH-1:0]     x_ty_reg;
    logic [FRAC_WIDTH-1:0]     x_tz_reg;
    logic [2:0]                x_flag_reg;

    logic                      y_valid_reg;
    logic signed [VW-1:0]      y_val_reg [2];
    logic [FRAC_WIDTH-1:0]     y_tz_reg;
    logic [2:0]                y_flag_reg;

    logic                      o_valid_reg;
    logic signed [VW-1:0]      o_val_reg;
    logic [2:0]                o_flag_reg;

    axis_t [2:0]               last_axes;
    logic [8*VW-1:0]           last_corn;

    assign en           = !(o_valid_reg && out_stall);
    assign pop          = en && q_not_empty;
    assign out_valid    = o_valid_reg;
    assign interpolated = o_val_reg;
    assign out_of_cell  = o_flag_reg;
    assign last_axes    = dv_axes_reg[DIV_STEPS-1];
    assign last_corn    = dv_corn_reg[DIV_STEPS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                dv_valid_reg[s] <= 1'b0;
            end
            x_valid_reg <= 1'b0;
            y_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= q_not_empty;
            for (int s = 1; s < DIV_STEPS; s++)
            begin
                dv_valid_reg[s] <= dv_valid_reg[s-1];
            end
            x_valid_reg <= dv_valid_reg[DIV_STEPS-1];
            y_valid_reg <= x_valid_reg;
            o_valid_reg <= y_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_axes_reg[0][i] <= div_step(axes_in[i], cell_size[i]);
            end
            dv_corn_reg[0] <= corners_in;
            for (int s = 1; s < DIV_STEPS; s++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dv_axes_reg[s][i] <= div_step(dv_axes_reg[s-1][i], cell_size[i]);
                end
                dv_corn_reg[s] <= dv_corn_reg[s-1];
            end

            for (int j = 0; j < 4; j++)
            begin
                x_val_reg[j] <= lerp(last_corn[j*2*VW +: VW], last_corn[j*2*VW+VW +: VW],
                                     last_axes[0].quo);
            end
            x_ty_reg   <= last_axes[1].quo;
            x_tz_reg   <= last_axes[2].quo;
            x_flag_reg <= {last_axes[2].flag, last_axes[1].flag, last_axes[0].flag};

            y_val_reg[0] <= lerp(x_val_reg[0], x_val_reg[1], x_ty_reg);
            y_val_reg[1] <= lerp(x_val_reg[2], x_val_reg[3], x_ty_reg);
            y_tz_reg     <= x_tz_reg;
            y_flag_reg   <= x_flag_reg;

            o_val_reg  <= lerp(y_val_reg[0], y_val_reg[1], y_tz_reg);
            o_flag_reg <= y_flag_reg;
        end
    end

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(o_val_reg) && $stable(o_flag_reg) && o_valid_reg)
        else $error("result changed while held");
    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_not_empty && en)
        else $error("pop without data or while stalled");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        en && y_valid_reg |=> o_valid_reg)
        else $error("item lost before output");

endmodule

// ===== test/trilinear_interpolator_checker.sv =====
// ----------------------------------------------------------------------------
// trilinear_interpolator_checker
// watches the request and result channels of the trilinear interpolator,
// predicts each result from the accepted request and the cell sizes, and
// compares in order; mismatches are counted and handed to the testbench top
// ----------------------------------------------------------------------------
module trilinear_interpolator_checker
    import trilin_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [CELL_WIDTH-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic signed [31:0]     point_x,
    input  logic signed [31:0]     point_y,
    input  logic signed [31:0]     point_z,
    input  logic signed [31:0]     origin_x,
    input  logic signed [31:0]     origin_y,
    input  logic signed [31:0]     origin_z,
    input  logic [31:0]            corners_y0z0,
    input  logic [31:0]            corners_y1z0,
    input  logic [31:0]            corners_y0z1,
    input  logic [31:0]            corners_y1z1,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic signed [15:0]     interpolated,
    input  logic [2:0]             out_of_cell,
    output int                     errors,
    output int                     pending,
    output int                     results_seen,
    output int                     flagged_seen
);

    typedef struct packed {
        logic signed [15:0] value;
        logic [2:0]         flags;
    } sample_t;

    logic [31:0] size_x, size_y, size_z;
    sample_t     expected_q[$];

    function automatic logic [16:0] axis_frac(input logic signed [31:0] pt,
                                              input logic signed [31:0] org,
                                              input logic [31:0] size,
                                              output logic flag);
        longint d;
        d = longint'(pt) - longint'(org);
        flag = 1'b0;
        if (d < 0)
        begin
            flag = 1'b1;
            return 17'd0;
        end
        if (d > longint'({32'd0, size}))
        begin
            flag = 1'b1;
            return 17'h10000;
        end
        if (d == 0)
            return 17'd0;
        return 17'((d << 16) / longint'({32'd0, size}));
    endfunction

    function automatic longint blend(input longint a, input longint b, input logic [16:0] t)
    ;
        longint acc;
        acc = a * (65536 - longint'({47'd0, t})) + b * longint'({47'd0, t});
        return acc >>> 16;
    endfunction

    function automatic longint lo_half(input logic [31:0] p);
        return longint'($signed(p[15:0]));
    endfunction

    function automatic longint hi_half(input logic [31:0] p);
        return longint'($signed(p[31:16]));
    endfunction

    function automatic sample_t interpolate_point();
        sample_t     s;
        logic        fx, fy, fz;
        logic [16:0] tx, ty, tz;
        longint      v00, v10, v01, v11, v0, v1, r;
        tx  = axis_frac(point_x, origin_x, size_x, fx);
        ty  = axis_frac(point_y, origin_y, size_y, fy);
        tz  = axis_frac(point_z, origin_z, size_z, fz);
        v00 = blend(lo_half(corners_y0z0), hi_half(corners_y0z0), tx);
        v10 = blend(lo_half(corners_y1z0), hi_half(corners_y1z0), tx);
        v01 = blend(lo_half(corners_y0z1), hi_half(corners_y0z1), tx);
        v11 = blend(lo_half(corners_y1z1), hi_half(corners_y1z1), tx);
        v0  = blend(v00, v10, ty);
        v1  = blend(v01, v11, ty);
        r   = blend(v0, v1, tz);
        s.value = r[15:0];
        s.flags = {fz, fy, fx};
        return s;
    endfunction

    task automatic report(input string what);
        $display("error at %0t: %s", $realtime, what);
        errors++;
    endtask

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        sample_t exp_s;
        if (!rst_n)
        begin
            size_x = CELL_RESET;
            size_y = CELL_RESET;
            size_z = CELL_RESET;
            expected_q.delete();
            errors = 0;
            results_seen = 0;
            flagged_seen = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (out_of_cell != 3'd0)
                    flagged_seen++;
                if (expected_q.size() == 0)
                    report("result with no request outstanding");
                else
                begin
                    exp_s = expected_q.pop_front();
                    if (interpolated !== exp_s.value)
                        report($sformatf("interpolated %0d, expected %0d",
                                         interpolated, exp_s.value));
                    if (out_of_cell !== exp_s.flags)
                        report($sformatf("out_of_cell %b, expected %b",
                                         out_of_cell, exp_s.flags));
                end
            end
            if (in_valid && !in_stall)
                expected_q.push_back(interpolate_point());
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CELL_X: size_x = cfg_data;
                    CFG_CELL_Y: size_y = cfg_data;
                    CFG_CELL_Z: size_z = cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== test/trilinear_interpolator_core_tb.sv =====
// ----------------------------------------------------------------------------
// trilinear_interpolator_core_tb
// drives directed and random query points through the interpolator under
// several cell size settings and random idling on both channels; the checker
// predicts and compares every result
// ----------------------------------------------------------------------------
module trilinear_interpolator_core_tb;
    import trilin_pkg::*;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = CFG_CELL_X;
    logic [CELL_WIDTH-1:0]    cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [31:0]       point_x = '0, point_y = '0, point_z = '0;
    logic signed [31:0]       origin_x = '0, origin_y = '0, origin_z = '0;
    logic [31:0]              corners_y0z0 = '0, corners_y1z0 = '0;
    logic [31:0]              corners_y0z1 = '0, corners_y1z1 = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [15:0]       interpolated;
    logic [2:0]               out_of_cell;
    int                       errors, pending, results_seen, flagged_seen;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_off = 1'b0;
    longint cycles = 0;
    localparam longint CYCLE_LIMIT = 400000;

    always #5 clk = ~clk;

    trilinear_interpolator_core i_dut (.*);

    trilinear_interpolator_checker i_checker (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("trilinear_interpolator_core: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_sizes(input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] sz);
        wait_drained();
        write_reg(CFG_CELL_X, sx);
        write_reg(CFG_CELL_Y, sy);
        write_reg(CFG_CELL_Z, sz);
        cfg_we <= 1'b0;
    endtask

    // presents one request and holds it until accepted
    task automatic send_query(input logic [31:0] px, py, pz, ox, oy, oz,
                              input logic [31:0] c0, c1, c2, c3);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        point_x      <= px;
        point_y      <= py;
        point_z      <= pz;
        origin_x     <= ox;
        origin_y     <= oy;
        origin_z     <= oz;
        corners_y0z0 <= c0;
        corners_y1z0 <= c1;
        corners_y0z1 <= c2;
        corners_y1z1 <= c3;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_size();
        case ($urandom_range(5))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 255);
            3: return $urandom();
            default: return $urandom_range(32'h0000_4000, 32'h0008_0000);
        endcase
    endfunction

    // mostly points inside or near the cell, some anywhere at all
    task automatic random_query(input logic [31:0] sx, sy, sz);
        logic [31:0] o [3];
        logic [31:0] p [3];
        logic [31:0] s [3];
        s = '{sx, sy, sz};
        for (int a = 0; a < 3; a++)
        begin
            o[a] = $urandom();
            case ($urandom_range(9))
                0: p[a] = $urandom();
                1: p[a] = o[a] - $urandom_range(1, 1000);
                2: p[a] = o[a] + s[a] + $urandom_range(0, 3);
                3: p[a] = o[a];
                default: p[a] = o[a] + 32'(longint'(s[a]) * $urandom_range(0, 1023) / 1024);
            endcase
        end
        send_query(p[0], p[1], p[2], o[0], o[1], o[2],
                   $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    task automatic random_phase(input int n);
        logic [31:0] sx, sy, sz;
        sx = pick_size();
        sy = pick_size();
        sz = pick_size();
        set_sizes(sx, sy, sz);
        for (int i = 0; i < n; i++)
            random_query(sx, sy, sz);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes: corners, centre, below and beyond the cell, extremes
        send_query(0, 0, 0, 0, 0, 0, 32'h7FFF_8000, 32'h8000_7FFF, 32'hFFFF_0001, 32'h1234_5678);
        send_query(32'h10000, 32'h10000, 32'h10000, 0, 0, 0,
                   32'h7FFF_8000, 32'h8000_7FFF, 32'hFFFF_0001, 32'h7FFF_7FFF);
        send_query(32'h8000, 32'h8000, 32'h8000, 0, 0, 0,
                   32'h7FFF_8000, 32'h8000_8000, 32'h7FFF_7FFF, 32'hFFFF_FFFF);
        send_query(32'hFFFF_FFFF, 32'h10001, 32'h4000, 0, 0, 0,
                   32'h8000_8000, 32'h0100_FF00, 32'h0000_0001, 32'hFFFF_8000);
        send_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0000, 32'hAAAA_5555, 32'h5555_AAAA,
                   32'hFFFF_FFFF, 32'h0000_0000);
        send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8001_7FFF, 32'h0001_FFFF,
                   32'h7FFF_8001, 32'hFFFE_0002);
        send_query(32'h1, 32'hFFFF, 32'h0C000, 0, 0, 0, 32'h7FFF_8000, 32'h7FFF_8000,
                   32'h8000_7FFF, 32'h8000_7FFF);

        // tiny cells, then largest cells, then a zero-size cell on the x axis
        set_sizes(32'd1, 32'd1, 32'd1);
        send_query(1, 0, 2, 0, 0, 0, 32'h7FFF_8000, 32'h0100_0200, 32'h8000_7FFF, 32'hFFFF_0001);
        send_query(5, 5, 5, 5, 4, 6, 32'h4000_C000, 32'h0100_0200, 32'h1111_2222, 32'h8000_8000);
        set_sizes(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_query(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0001, 32'h7FFF_8000, 32'h8000_7FFF, 32'h0001_FFFF, 32'h1234_5678);
        send_query(32'h7FFF_FFFF, 32'h3FFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000, 0,
                   32'h7FFF_8000, 32'h8000_7FFF, 32'h0001_FFFF, 32'h1234_5678);
        set_sizes(32'd0, 32'd3, 32'h0003_0000);
        send_query(7, 7, 32'h30000, 7, 10, 0, 32'h0400_0200, 32'h8000_7FFF,
                   32'h1234_5678, 32'h7FFF_8000);
        send_query(8, 9, 32'h18000, 7, 7, 0, 32'h0400_0200, 32'h8000_7FFF,
                   32'h1234_5678, 32'h7FFF_8000);

        send_idle_pct = 7;
        recv_idle_pct = 52;
        for (int ph = 0; ph < 4; ph++)
            random_phase(90);

        // long receiver hold-off while requests keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 60; i++)
                random_query(32'h10000, 32'h10000, 32'h10000);
        join
        send_idle_pct = 52;
        recv_idle_pct = 7;
        for (int ph = 0; ph < 4; ph++)
            random_phase(90);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int ph = 0; ph < 3; ph++)
            random_phase(90);
        set_sizes(32'h10000, 32'h10000, 32'h10000);
        for (int i = 0; i < 50; i++)
            random_query(32'h10000, 32'h10000, 32'h10000);

        wait_drained();
        $display("%0d results checked, %0d of them with a clamped axis", results_seen,
                 flagged_seen);
        $display("cell sizes from 0 and 1 up to the maximum, idling on both sides");
        if (errors == 0)
            $display("trilinear_interpolator_core: match");
        else
            $display("trilinear_interpolator_core: mismatch");
        $finish;
    end

endmodule
